### sv/cedv_pkg.sv
// Shared types, constants and tables for the cell edge direction vote block.
package cedv_pkg;

  // Fixed limits of the design.
  localparam int MAX_LINE_WIDTH       = 2048;
  localparam int MAX_IMAGE_HEIGHT     = 2048;
  localparam int MAX_CELL             = 16;
  localparam int DEF_MAX_CELL_COLUMNS = 256;

  // Field and register widths.
  localparam int DIM_W      = 12;
  localparam int POS_W      = 11;
  localparam int OFS_W      = 4;
  localparam int CSZ_W      = 5;
  localparam int MINC_W     = 9;
  localparam int MAG_W      = 15;
  localparam int ANG_W      = 13;
  localparam int DIR_W      = 2;
  localparam int GLYPH_W    = 7;
  localparam int ROW_W      = 11;
  localparam int COL_W      = 8;
  localparam int CNT_W      = 9;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 15;

  // Division by a cell size (1 to MAX_CELL) is a multiply by ceil(2^16 / size).
  // The quotient is exact for every dividend below 4096.
  localparam int RECIP_SHIFT = 16;
  localparam int RECIP_W     = 17;
  localparam logic [RECIP_W-1:0] RECIP [MAX_CELL+1] = '{
    17'd0,     17'd65536, 17'd32768, 17'd21846, 17'd16384, 17'd13108,
    17'd10923, 17'd9363,  17'd8192,  17'd7282,  17'd6554,  17'd5958,
    17'd5462,  17'd5042,  17'd4682,  17'd4370,  17'd4096
  };

  // Angles in 1/16 degree: half turn and the bin edges.
  localparam logic [ANG_W-1:0] FOLD_UNITS = 13'd2880;
  localparam logic [ANG_W-1:0] EDGE_A     = 13'd360;
  localparam logic [ANG_W-1:0] EDGE_B     = 13'd1080;
  localparam logic [ANG_W-1:0] EDGE_C     = 13'd1800;
  localparam logic [ANG_W-1:0] EDGE_D     = 13'd2520;

  typedef enum logic [DIR_W-1:0] {
    DIR_HORIZONTAL = 2'd0,
    DIR_RISING     = 2'd1,
    DIR_VERTICAL   = 2'd2,
    DIR_FALLING    = 2'd3
  } dir_e;

  localparam logic [GLYPH_W-1:0] GLYPH_BLANK = 7'd32;
  localparam logic [GLYPH_W-1:0] GLYPH_OF [4] = '{7'd45, 7'd47, 7'd124, 7'd92};

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IMAGE_WIDTH   = 3'd0,
    CFG_IMAGE_HEIGHT  = 3'd1,
    CFG_CELL_WIDTH    = 3'd2,
    CFG_CELL_HEIGHT   = 3'd3,
    CFG_MIN_COUNT     = 3'd4,
    CFG_MAG_THRESHOLD = 3'd5
  } cfg_index_e;

  localparam int RST_IMAGE_WIDTH   = 640;
  localparam int RST_IMAGE_HEIGHT  = 480;
  localparam int RST_CELL_WIDTH    = 8;
  localparam int RST_CELL_HEIGHT   = 8;
  localparam int RST_MIN_COUNT     = 12;
  localparam int RST_MAG_THRESHOLD = 160;

  // Saturated sizes and the whole-cell limits derived from them.
  typedef struct packed {
    logic [DIM_W-1:0]  width;
    logic [DIM_W-1:0]  height;
    logic [CSZ_W-1:0]  cell_w;
    logic [CSZ_W-1:0]  cell_h;
    logic [MINC_W-1:0] min_count;
    logic [MAG_W-1:0]  mag_thr;
    logic [DIM_W-1:0]  ncols;
    logic [DIM_W-1:0]  lim_x;
    logic [DIM_W-1:0]  lim_y;
  } cfg_t;

  typedef struct packed {
    logic [POS_W-1:0] x;
    logic [POS_W-1:0] y;
    logic [OFS_W-1:0] ox;
    logic [OFS_W-1:0] oy;
  } pos_t;

  typedef struct packed {
    logic [3:0][CNT_W-1:0] count;
    logic [MAG_W-1:0]      peak;
  } acc_t;

  localparam int ACC_W = $bits(acc_t);

  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic             row_end;
    acc_t             acc;
  } cell_t;

endpackage

### sv/cedv_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module cedv_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // A read of the address being written returns the old contents.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### sv/cedv_cfg_regs.sv
// Configuration registers, size saturation and the derived whole-cell limits.
module cedv_cfg_regs import cedv_pkg::*; #(
  parameter int MAX_CELL_COLUMNS = DEF_MAX_CELL_COLUMNS
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output cfg_t                  cfg_o
);

  localparam int PROD_W = DIM_W + RECIP_W;
  localparam int RST_NCOLS_FULL = RST_IMAGE_WIDTH / RST_CELL_WIDTH;
  localparam int RST_NCOLS = (RST_NCOLS_FULL > MAX_CELL_COLUMNS) ? MAX_CELL_COLUMNS
                                                                 : RST_NCOLS_FULL;
  localparam int RST_LIM_X = RST_NCOLS * RST_CELL_WIDTH;
  localparam int RST_LIM_Y = (RST_IMAGE_HEIGHT / RST_CELL_HEIGHT) * RST_CELL_HEIGHT;
  localparam logic [PROD_W-1:0] RST_QW = PROD_W'(RST_IMAGE_WIDTH * RECIP[RST_CELL_WIDTH]);
  localparam logic [PROD_W-1:0] RST_QH = PROD_W'(RST_IMAGE_HEIGHT * RECIP[RST_CELL_HEIGHT]);

  logic [DIM_W-1:0]  image_width_q, image_height_q;
  logic [CSZ_W-1:0]  cell_width_q, cell_height_q;
  logic [MINC_W-1:0] min_count_q;
  logic [MAG_W-1:0]  mag_threshold_q;

  logic [DIM_W-1:0]  w_c, h_c;
  logic [CSZ_W-1:0]  cw_c, ch_c;

  logic [PROD_W-1:0] qw_d, qw_q, qh_d, qh_q;
  logic [DIM_W-1:0]  ncols_full, nrows;
  logic [DIM_W-1:0]  ncols_d, ncols_q;
  logic [DIM_W+CSZ_W-1:0] lim_x_prod, lim_y_prod;
  logic [DIM_W-1:0]  lim_x_d, lim_x_q, lim_y_d, lim_y_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      image_width_q   <= DIM_W'(RST_IMAGE_WIDTH);
      image_height_q  <= DIM_W'(RST_IMAGE_HEIGHT);
      cell_width_q    <= CSZ_W'(RST_CELL_WIDTH);
      cell_height_q   <= CSZ_W'(RST_CELL_HEIGHT);
      min_count_q     <= MINC_W'(RST_MIN_COUNT);
      mag_threshold_q <= MAG_W'(RST_MAG_THRESHOLD);
    end else if (cfg_valid_i) begin
      case (cfg_index_e'(cfg_index_i))
        CFG_IMAGE_WIDTH:   image_width_q   <= cfg_data_i[DIM_W-1:0];
        CFG_IMAGE_HEIGHT:  image_height_q  <= cfg_data_i[DIM_W-1:0];
        CFG_CELL_WIDTH:    cell_width_q    <= cfg_data_i[CSZ_W-1:0];
        CFG_CELL_HEIGHT:   cell_height_q   <= cfg_data_i[CSZ_W-1:0];
        CFG_MIN_COUNT:     min_count_q     <= cfg_data_i[MINC_W-1:0];
        CFG_MAG_THRESHOLD: mag_threshold_q <= cfg_data_i[MAG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    w_c = image_width_q;
    if (image_width_q == '0) w_c = DIM_W'(1);
    else if (image_width_q > DIM_W'(MAX_LINE_WIDTH)) w_c = DIM_W'(MAX_LINE_WIDTH);
    h_c = image_height_q;
    if (image_height_q == '0) h_c = DIM_W'(1);
    else if (image_height_q > DIM_W'(MAX_IMAGE_HEIGHT)) h_c = DIM_W'(MAX_IMAGE_HEIGHT);
    cw_c = cell_width_q;
    if (cell_width_q == '0) cw_c = CSZ_W'(1);
    else if (cell_width_q > CSZ_W'(MAX_CELL)) cw_c = CSZ_W'(MAX_CELL);
    ch_c = cell_height_q;
    if (cell_height_q == '0) ch_c = CSZ_W'(1);
    else if (cell_height_q > CSZ_W'(MAX_CELL)) ch_c = CSZ_W'(MAX_CELL);
  end

  // First step: image size times the reciprocal of the cell size.
  assign qw_d = PROD_W'(w_c) * PROD_W'(RECIP[cw_c]);
  assign qh_d = PROD_W'(h_c) * PROD_W'(RECIP[ch_c]);

  // Second step: cell counts back to pixel limits of the whole cells.
  always_comb begin
    ncols_full = qw_q[RECIP_SHIFT +: DIM_W];
    nrows      = qh_q[RECIP_SHIFT +: DIM_W];
    ncols_d    = (ncols_full > DIM_W'(MAX_CELL_COLUMNS)) ? DIM_W'(MAX_CELL_COLUMNS)
                                                         : ncols_full;
    lim_x_prod = (DIM_W+CSZ_W)'(ncols_d) * (DIM_W+CSZ_W)'(cw_c);
    lim_y_prod = (DIM_W+CSZ_W)'(nrows) * (DIM_W+CSZ_W)'(ch_c);
    lim_x_d    = lim_x_prod[DIM_W-1:0];
    lim_y_d    = lim_y_prod[DIM_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      qw_q    <= RST_QW;
      qh_q    <= RST_QH;
      ncols_q <= DIM_W'(RST_NCOLS);
      lim_x_q <= DIM_W'(RST_LIM_X);
      lim_y_q <= DIM_W'(RST_LIM_Y);
    end else begin
      qw_q    <= qw_d;
      qh_q    <= qh_d;
      ncols_q <= ncols_d;
      lim_x_q <= lim_x_d;
      lim_y_q <= lim_y_d;
    end
  end

  always_comb begin
    cfg_o.width     = w_c;
    cfg_o.height    = h_c;
    cfg_o.cell_w    = cw_c;
    cfg_o.cell_h    = ch_c;
    cfg_o.min_count = min_count_q;
    cfg_o.mag_thr   = mag_threshold_q;
    cfg_o.ncols     = ncols_q;
    cfg_o.lim_x     = lim_x_q;
    cfg_o.lim_y     = lim_y_q;
  end

endmodule

### sv/cedv_pos.sv
// Raster position, offset-in-cell and cell column counters.
module cedv_pos import cedv_pkg::*; #(
  parameter int MAX_CELL_COLUMNS = DEF_MAX_CELL_COLUMNS
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   accept_i,
  input  logic                                   frame_start_i,
  input  cfg_t                                   cfg_i,
  output pos_t                                   pos_o,
  output logic [$clog2(MAX_CELL_COLUMNS+1)-1:0] cc_o
);

  localparam int CCW = $clog2(MAX_CELL_COLUMNS + 1);

  pos_t             pos_q, pos_d, cur;
  logic [CCW-1:0]   cc_q, cc_d, cc_cur;
  logic [DIM_W-1:0] x_inc, y_inc;
  logic [CSZ_W-1:0] ox_inc, oy_inc;

  // A frame start puts the pixel itself at the origin.
  always_comb begin
    cur    = frame_start_i ? '0 : pos_q;
    cc_cur = frame_start_i ? '0 : cc_q;
  end

  always_comb begin
    x_inc  = DIM_W'(cur.x) + DIM_W'(1);
    y_inc  = DIM_W'(cur.y) + DIM_W'(1);
    ox_inc = CSZ_W'(cur.ox) + CSZ_W'(1);
    oy_inc = CSZ_W'(cur.oy) + CSZ_W'(1);
    pos_d  = cur;
    cc_d   = cc_cur;
    if (ox_inc >= cfg_i.cell_w) begin
      pos_d.ox = '0;
      if (cc_cur < CCW'(MAX_CELL_COLUMNS)) cc_d = cc_cur + CCW'(1);
    end else begin
      pos_d.ox = ox_inc[OFS_W-1:0];
    end
    if (x_inc >= cfg_i.width) begin
      pos_d.x  = '0;
      pos_d.ox = '0;
      cc_d     = '0;
      if (y_inc >= cfg_i.height) begin
        pos_d.y  = '0;
        pos_d.oy = '0;
      end else begin
        pos_d.y  = y_inc[POS_W-1:0];
        pos_d.oy = (oy_inc >= cfg_i.cell_h) ? '0 : oy_inc[OFS_W-1:0];
      end
    end else begin
      pos_d.x = x_inc[POS_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
      cc_q  <= '0;
    end else if (accept_i) begin
      pos_q <= pos_d;
      cc_q  <= cc_d;
    end
  end

  assign pos_o = cur;
  assign cc_o  = cc_cur;

endmodule

### sv/cedv_accum.sv
// Read-modify-write pipeline over the per-column accumulator RAM.
module cedv_accum import cedv_pkg::*; #(
  parameter int MAX_CELL_COLUMNS = DEF_MAX_CELL_COLUMNS
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   en_i,
  input  logic                                   accept_i,
  input  pos_t                                   pos_i,
  input  logic [$clog2(MAX_CELL_COLUMNS+1)-1:0] cc_i,
  input  logic [MAG_W-1:0]                       magnitude_i,
  input  logic [ANG_W-1:0]                       angle_i,
  input  cfg_t                                   cfg_i,
  output logic                                   res_valid_o,
  output logic [$clog2(MAX_CELL_COLUMNS+1)-1:0] res_cc_o,
  output cell_t                                  res_o
);

  localparam int CCW    = $clog2(MAX_CELL_COLUMNS + 1);
  localparam int AW     = $clog2(MAX_CELL_COLUMNS);
  localparam int YMUL_W = POS_W + RECIP_W;

  // Stage 1: position captured, RAM read issued.
  logic             p1_valid_q;
  pos_t             p1_pos_q;
  logic [CCW-1:0]   p1_cc_q;
  logic [MAG_W-1:0] p1_mag_q;
  logic [ANG_W-1:0] p1_angle_q;

  logic [ANG_W-1:0]  ang_f;
  dir_e              dir;
  logic [YMUL_W-1:0] ymul;

  // Stage 2: RAM data back, accumulator updated and written.
  logic             p2_valid_q;
  pos_t             p2_pos_q;
  logic [CCW-1:0]   p2_cc_q;
  logic [MAG_W-1:0] p2_mag_q;
  dir_e             p2_dir_q;
  logic [ROW_W-1:0] p2_row_q;

  logic [ACC_W-1:0] rdata;
  acc_t             old_acc, acc_new;
  logic             hit, last, row_end;
  logic [DIM_W-1:0] cc_ext;
  logic [CSZ_W-1:0] ox_inc, oy_inc;
  logic             we;

  // Last write, forwarded to a read of the same entry that it overtook.
  logic             wb_valid_q;
  logic [AW-1:0]    wb_addr_q;
  acc_t             wb_data_q;

  // Stage 3 registers feed the result logic.
  logic             p3_valid_q;
  logic [CCW-1:0]   p3_cc_q;
  cell_t            p3_cell_q;

  always_comb begin
    if (p1_angle_q >= (FOLD_UNITS << 1)) begin
      ang_f = p1_angle_q - (FOLD_UNITS << 1);
    end else if (p1_angle_q >= FOLD_UNITS) begin
      ang_f = p1_angle_q - FOLD_UNITS;
    end else begin
      ang_f = p1_angle_q;
    end
    if (ang_f < EDGE_A || ang_f >= EDGE_D) dir = DIR_HORIZONTAL;
    else if (ang_f < EDGE_B) dir = DIR_RISING;
    else if (ang_f < EDGE_C) dir = DIR_VERTICAL;
    else dir = DIR_FALLING;
    ymul = YMUL_W'(p1_pos_q.y) * YMUL_W'(RECIP[cfg_i.cell_h]);
  end

  cedv_ram #(
    .WIDTH (ACC_W),
    .DEPTH (MAX_CELL_COLUMNS)
  ) u_acc_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (p2_cc_q[AW-1:0]),
    .wdata_i (acc_new),
    .re_i    (en_i),
    .raddr_i (p1_cc_q[AW-1:0]),
    .rdata_o (rdata)
  );

  always_comb begin
    cc_ext  = DIM_W'(p2_cc_q);
    ox_inc  = CSZ_W'(p2_pos_q.ox) + CSZ_W'(1);
    oy_inc  = CSZ_W'(p2_pos_q.oy) + CSZ_W'(1);
    hit     = p2_valid_q && (DIM_W'(p2_pos_q.x) < cfg_i.lim_x) &&
              (DIM_W'(p2_pos_q.y) < cfg_i.lim_y) && (cc_ext < cfg_i.ncols);
    last    = hit && (ox_inc == cfg_i.cell_w) && (oy_inc == cfg_i.cell_h);
    row_end = (cc_ext + DIM_W'(1)) == cfg_i.ncols;

    if (p2_pos_q.ox == '0 && p2_pos_q.oy == '0) begin
      old_acc = '0;
    end else if (wb_valid_q && wb_addr_q == p2_cc_q[AW-1:0]) begin
      old_acc = wb_data_q;
    end else begin
      old_acc = acc_t'(rdata);
    end

    acc_new = old_acc;
    acc_new.count[p2_dir_q] = old_acc.count[p2_dir_q] + CNT_W'(1);
    if (p2_mag_q > old_acc.peak) acc_new.peak = p2_mag_q;
    we = en_i && hit;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_valid_q <= 1'b0;
      p2_valid_q <= 1'b0;
      p3_valid_q <= 1'b0;
      wb_valid_q <= 1'b0;
    end else if (en_i) begin
      p1_valid_q <= accept_i;
      p2_valid_q <= p1_valid_q;
      p3_valid_q <= last;
      wb_valid_q <= hit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p1_pos_q   <= pos_i;
      p1_cc_q    <= cc_i;
      p1_mag_q   <= magnitude_i;
      p1_angle_q <= angle_i;
      p2_pos_q   <= p1_pos_q;
      p2_cc_q    <= p1_cc_q;
      p2_mag_q   <= p1_mag_q;
      p2_dir_q   <= dir;
      p2_row_q   <= ymul[RECIP_SHIFT +: ROW_W];
      wb_addr_q  <= p2_cc_q[AW-1:0];
      wb_data_q  <= acc_new;
      p3_cc_q    <= p2_cc_q;
      p3_cell_q.row     <= p2_row_q;
      p3_cell_q.row_end <= row_end;
      p3_cell_q.acc     <= acc_new;
    end
  end

  assign res_valid_o = p3_valid_q;
  assign res_cc_o    = p3_cc_q;
  assign res_o       = p3_cell_q;

endmodule

### sv/cedv_result.sv
// Winner selection, weak-vote and glyph decisions, and the output register.
module cedv_result import cedv_pkg::*; #(
  parameter int MAX_CELL_COLUMNS = DEF_MAX_CELL_COLUMNS
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   out_stall_i,
  input  logic                                   res_valid_i,
  input  logic [$clog2(MAX_CELL_COLUMNS+1)-1:0] res_cc_i,
  input  cell_t                                  res_i,
  input  cfg_t                                   cfg_i,
  output logic                                   en_o,
  output logic                                   out_valid_o,
  output logic [COL_W-1:0]                       cell_column_o,
  output logic [ROW_W-1:0]                       cell_row_o,
  output logic [MAG_W-1:0]                       cell_peak_o,
  output logic [DIR_W-1:0]                       direction_o,
  output logic [GLYPH_W-1:0]                     glyph_o,
  output logic                                   row_end_o
);

  localparam int CCW = $clog2(MAX_CELL_COLUMNS + 1);

  dir_e                 win;
  logic [MAG_W-1:0]     peak;
  logic [GLYPH_W-1:0]   glyph;
  logic [CCW+COL_W-1:0] col_ext;

  logic                 out_valid_q;
  logic [COL_W-1:0]     column_q;
  logic [ROW_W-1:0]     row_q;
  logic [MAG_W-1:0]     peak_q;
  dir_e                 dir_q;
  logic [GLYPH_W-1:0]   glyph_q;
  logic                 row_end_q;

  // Ties keep the lower direction index.
  always_comb begin
    win = DIR_HORIZONTAL;
    if (res_i.acc.count[DIR_RISING] > res_i.acc.count[win]) win = DIR_RISING;
    if (res_i.acc.count[DIR_VERTICAL] > res_i.acc.count[win]) win = DIR_VERTICAL;
    if (res_i.acc.count[DIR_FALLING] > res_i.acc.count[win]) win = DIR_FALLING;
    peak    = (MINC_W'(res_i.acc.count[win]) < cfg_i.min_count) ? '0 : res_i.acc.peak;
    glyph   = (peak > cfg_i.mag_thr) ? GLYPH_OF[win] : GLYPH_BLANK;
    col_ext = {COL_W'(0), res_cc_i};
  end

  // The pipeline moves whenever the output register is free or being taken.
  assign en_o = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en_o) begin
      out_valid_q <= res_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_o && res_valid_i) begin
      column_q  <= col_ext[COL_W-1:0];
      row_q     <= res_i.row;
      peak_q    <= peak;
      dir_q     <= win;
      glyph_q   <= glyph;
      row_end_q <= res_i.row_end;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign cell_column_o = column_q;
  assign cell_row_o    = row_q;
  assign cell_peak_o   = peak_q;
  assign direction_o   = dir_q;
  assign glyph_o       = glyph_q;
  assign row_end_o     = row_end_q;

endmodule

### sv/cell_edge_direction_vote_core.sv
// A cell result follows the cell's last pixel through the p1, p2 and p3 registers and the output register.
// Throughput: one pixel per cycle while the output is not stalled; the accumulator RAM is
// read one stage ahead of its write-back, and a one-entry forward covers back-to-back pixels
// of the same cell column. Size changes reach the whole-cell limits through the product
// registers. Reset clears positions and pipeline valids and loads the configuration reset
// values; the RAM is not cleared, since every cell restarts its accumulator on its first pixel.
module cell_edge_direction_vote_core import cedv_pkg::*; #(
  parameter int MAX_CELL_COLUMNS = DEF_MAX_CELL_COLUMNS
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic                  frame_start_i,
  input  logic [MAG_W-1:0]      magnitude_i,
  input  logic [ANG_W-1:0]      angle_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [COL_W-1:0]      cell_column_o,
  output logic [ROW_W-1:0]      cell_row_o,
  output logic [MAG_W-1:0]      cell_peak_o,
  output logic [DIR_W-1:0]      direction_o,
  output logic [GLYPH_W-1:0]    glyph_o,
  output logic                  row_end_o
);

  localparam int CCW = $clog2(MAX_CELL_COLUMNS + 1);

  cfg_t           cfg;
  pos_t           pos;
  logic [CCW-1:0] cc;
  logic           en, accept;
  logic           res_valid;
  logic [CCW-1:0] res_cc;
  cell_t          res;

  assign cfg_ready_o = 1'b1;
  assign accept      = in_valid_i && en;
  assign in_stall_o  = !en;

  cedv_cfg_regs #(
    .MAX_CELL_COLUMNS (MAX_CELL_COLUMNS)
  ) u_cfg_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  cedv_pos #(
    .MAX_CELL_COLUMNS (MAX_CELL_COLUMNS)
  ) u_pos (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .frame_start_i (frame_start_i),
    .cfg_i         (cfg),
    .pos_o         (pos),
    .cc_o          (cc)
  );

  cedv_accum #(
    .MAX_CELL_COLUMNS (MAX_CELL_COLUMNS)
  ) u_accum (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (en),
    .accept_i    (accept),
    .pos_i       (pos),
    .cc_i        (cc),
    .magnitude_i (magnitude_i),
    .angle_i     (angle_i),
    .cfg_i       (cfg),
    .res_valid_o (res_valid),
    .res_cc_o    (res_cc),
    .res_o       (res)
  );

  cedv_result #(
    .MAX_CELL_COLUMNS (MAX_CELL_COLUMNS)
  ) u_result (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .out_stall_i   (out_stall_i),
    .res_valid_i   (res_valid),
    .res_cc_i      (res_cc),
    .res_i         (res),
    .cfg_i         (cfg),
    .en_o          (en),
    .out_valid_o   (out_valid_o),
    .cell_column_o (cell_column_o),
    .cell_row_o    (cell_row_o),
    .cell_peak_o   (cell_peak_o),
    .direction_o   (direction_o),
    .glyph_o       (glyph_o),
    .row_end_o     (row_end_o)
  );

endmodule

### sv/cedv_checker.sv
// Port-level checks of the vote core, bound to its top level.
module cedv_checker import cedv_pkg::*; (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  cfg_valid_i,
  input logic                  cfg_ready_o,
  input logic [CFG_IDX_W-1:0]  cfg_index_i,
  input logic [CFG_DATA_W-1:0] cfg_data_i,
  input logic                  in_valid_i,
  input logic                  in_stall_o,
  input logic                  frame_start_i,
  input logic [MAG_W-1:0]      magnitude_i,
  input logic [ANG_W-1:0]      angle_i,
  input logic                  out_valid_o,
  input logic                  out_stall_i,
  input logic [COL_W-1:0]      cell_column_o,
  input logic [ROW_W-1:0]      cell_row_o,
  input logic [MAG_W-1:0]      cell_peak_o,
  input logic [DIR_W-1:0]      direction_o,
  input logic [GLYPH_W-1:0]    glyph_o,
  input logic                  row_end_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result withdrawn while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(cell_column_o) && $stable(cell_row_o) &&
      $stable(cell_peak_o) && $stable(direction_o) && $stable(glyph_o) &&
      $stable(row_end_o))
    else $error("stalled result changed");

  // An empty output register must never hold back the pixel stream.
  a_accept_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("input stalled with an empty output");

  a_glyph_matches_dir: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && glyph_o != GLYPH_BLANK |->
      (direction_o == DIR_HORIZONTAL && glyph_o == GLYPH_OF[0]) ||
      (direction_o == DIR_RISING     && glyph_o == GLYPH_OF[1]) ||
      (direction_o == DIR_VERTICAL   && glyph_o == GLYPH_OF[2]) ||
      (direction_o == DIR_FALLING    && glyph_o == GLYPH_OF[3]))
    else $error("glyph does not match direction");

  a_weak_is_blank: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && cell_peak_o == '0 |-> glyph_o == GLYPH_BLANK)
    else $error("glyph drawn for a zero peak");

endmodule

bind cell_edge_direction_vote_core cedv_checker u_checker (.*);
